[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");

`endif

[rtl/cgts_pkg.sv]
// ---------------------------------------------------------------------------
// cgts_pkg
// Types and constants shared by the topic sampler modules.
// ---------------------------------------------------------------------------
package cgts_pkg;

   localparam int TOPIC_BITS  = 6;
   localparam int NUM_TOPICS  = 64;
   localparam int DOC_BITS    = 10;
   localparam int WORD_BITS   = 12;
   localparam int COUNT_BITS  = 20;
   localparam int TOTAL_BITS  = 24;
   localparam int VOCAB_BITS  = 13;
   localparam int ETA_BITS    = 32;
   localparam int VDEN_BITS   = VOCAB_BITS + ETA_BITS;
   localparam int NUM_BITS    = 37;
   localparam int DEN_BITS    = 46;
   localparam int FAC_BITS    = 38;
   localparam int Q_BITS      = 48;
   localparam int CHUNK_BITS  = 19;
   localparam int PROD_BITS   = Q_BITS + CHUNK_BITS;
   localparam int ACC_BITS    = 112;
   localparam int SUM_BITS    = 64;
   localparam int CLR_BITS    = WORD_BITS + TOPIC_BITS;
   localparam int DIV_STEPS   = 48;
   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 8;
   localparam int CSR_ADDR_BITS = 8;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_PRIOR_ETA    = 8'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_VOCAB_IN_USE = 8'd1;

   localparam logic [ETA_BITS-1:0]   ETA_RESET   = 32'd65536;
   localparam logic [VOCAB_BITS-1:0] VOCAB_RESET = 13'd4096;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_LOAD, ST_DEC_RD, ST_DEC_WR,
      ST_W_RD, ST_W_LD, ST_DIV, ST_MUL, ST_ACC, ST_TMUL,
      ST_SRCH, ST_SRCH_CMP, ST_INC_RD, ST_INC_WR, ST_DONE
   } state_type;

   typedef enum logic {
      MUL_WEIGHT,
      MUL_TARGET
   } mul_mode_type;

   typedef struct packed {
      logic                  latch_item;
      logic                  clear_wr;
      logic [CLR_BITS-1:0]   clear_addr;
      logic                  wr_dec;
      logic                  wr_inc;
      logic                  wr_shape;
      logic [TOPIC_BITS-1:0] topic;
      logic                  w_load;
      logic                  div_step;
      logic                  mul_step;
      logic                  mul_first;
      mul_mode_type          mul_mode;
      logic [1:0]            chunk;
      logic                  acc_write;
      logic                  rsp_load;
   } cmd_type;

   typedef struct packed {
      logic                  sample;
      logic                  old_valid;
      logic [TOPIC_BITS-1:0] old_topic;
      logic                  cum_ge;
      logic                  out_free;
   } status_type;

endpackage

[rtl/cgts_ram.sv]
// ---------------------------------------------------------------------------
// cgts_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cgts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/cgts_ctrl.sv]
// ---------------------------------------------------------------------------
// cgts_ctrl
// Sequencer: clearing pass, shape load, count update, topic walk, search, result.
// ---------------------------------------------------------------------------
module cgts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  cgts_pkg::status_type status,
   output cgts_pkg::cmd_type    cmd,
   output cgts_pkg::state_type  state
);

   import cgts_pkg::*;

   state_type             state_ff, state_in;
   logic [TOPIC_BITS-1:0] k_ff, k_in;
   logic [5:0]            step_ff, step_in;
   logic [1:0]            chunk_ff, chunk_in;
   logic [TOPIC_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CLR_BITS-1:0]   clr_ff, clr_in;
   logic [TOPIC_BITS:0]   mid_sum;

   assign state   = state_ff;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      k_ff     <= k_in;
      step_ff  <= step_in;
      chunk_ff <= chunk_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      step_in    = step_ff;
      chunk_in   = chunk_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      clr_in     = clr_ff;
      cmd        = '0;
      cmd.mul_mode = MUL_WEIGHT;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr   = 1'b1;
            cmd.clear_addr = clr_ff;
            clr_in         = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_item = 1'b1;
               state_in       = ST_START;
            end
         end
         ST_START: begin
            k_in = '0;
            if (!status.sample) begin
               state_in = ST_LOAD;
            end else if (status.old_valid) begin
               state_in = ST_DEC_RD;
            end else begin
               state_in = ST_W_RD;
            end
         end
         ST_LOAD: begin
            cmd.wr_shape = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DEC_RD: begin
            cmd.topic = status.old_topic;
            state_in  = ST_DEC_WR;
         end
         ST_DEC_WR: begin
            cmd.topic  = status.old_topic;
            cmd.wr_dec = 1'b1;
            state_in   = ST_W_RD;
         end
         ST_W_RD: begin
            cmd.topic = k_ff;
            state_in  = ST_W_LD;
         end
         ST_W_LD: begin
            cmd.topic  = k_ff;
            cmd.w_load = 1'b1;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.topic    = k_ff;
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == 6'(DIV_STEPS - 1)) begin
               chunk_in = 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.topic     = k_ff;
            cmd.mul_step  = 1'b1;
            cmd.chunk     = chunk_ff;
            cmd.mul_first = (chunk_ff == 2'd1);
            chunk_in      = chunk_ff - 1'b1;
            if (chunk_ff == 2'd0) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.topic     = k_ff;
            cmd.acc_write = 1'b1;
            k_in          = k_ff + 1'b1;
            if (&k_ff) begin
               chunk_in = 2'd3;
               state_in = ST_TMUL;
            end else begin
               state_in = ST_W_RD;
            end
         end
         ST_TMUL: begin
            cmd.mul_step  = 1'b1;
            cmd.mul_mode  = MUL_TARGET;
            cmd.chunk     = chunk_ff;
            cmd.mul_first = (chunk_ff == 2'd3);
            chunk_in      = chunk_ff - 1'b1;
            lo_in         = '0;
            hi_in         = '1;
            if (chunk_ff == 2'd0) begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            // answer lies in [lo, hi]; cumulative sums never decrease
            if (lo_ff == hi_ff) begin
               k_in     = lo_ff;
               state_in = ST_INC_RD;
            end else begin
               cmd.topic = mid_sum[TOPIC_BITS:1];
               mid_in    = mid_sum[TOPIC_BITS:1];
               state_in  = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            cmd.topic = mid_ff;
            if (status.cum_ge) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = ST_SRCH;
         end
         ST_INC_RD: begin
            cmd.topic = k_ff;
            state_in  = ST_INC_WR;
         end
         ST_INC_WR: begin
            cmd.topic  = k_ff;
            cmd.wr_inc = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            cmd.topic = k_ff;
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/cgts_dp.sv]
// ---------------------------------------------------------------------------
// cgts_dp
// Datapath: count and shape tables, divider, multiplier, cumulative sums, output beat.
// ---------------------------------------------------------------------------
module cgts_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cgts_pkg::cmd_type                    cmd,
   output cgts_pkg::status_type                 status,
   input  logic [cgts_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   input  logic [cgts_pkg::ETA_BITS-1:0]        prior_eta,
   input  logic [cgts_pkg::VOCAB_BITS-1:0]      vocab_in_use,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cgts_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast
);

   import cgts_pkg::*;

   // latched item
   logic [WORD_BITS-1:0]  word_ff;
   logic [DOC_BITS-1:0]   doc_ff;
   logic [6:0]            cur_ff;
   logic [TOPIC_BITS-1:0] lt_ff;
   logic [31:0]           shape_ff, rf_ff;
   logic                  last_ff, sample_ff;
   logic [VDEN_BITS-1:0]  vden_ff;

   // weight datapath
   logic [DEN_BITS-1:0]   den_ff;
   logic [FAC_BITS-1:0]   fac_ff;
   logic                  sat_ff;
   logic [DEN_BITS-1:0]   rem_ff;
   logic [Q_BITS-1:0]     dsh_ff, q_ff;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [SUM_BITS-1:0]   sum_ff;
   logic                  under_ff;

   logic                  rsp_valid_ff;
   logic [6:0]            rsp_topic_ff;
   logic                  rsp_under_ff, rsp_last_ff;

   // RAM ports
   logic [COUNT_BITS-1:0] doc_rd, word_rd, doc_wd, word_wd;
   logic [TOTAL_BITS-1:0] tot_rd, tot_wd;
   logic [31:0]           shape_rd, shape_wd;
   logic [SUM_BITS-1:0]   cum_rd;
   logic [DOC_BITS+TOPIC_BITS-1:0]  doc_addr, shape_addr;
   logic [WORD_BITS+TOPIC_BITS-1:0] word_addr;
   logic [TOPIC_BITS-1:0] tot_addr;
   logic                  cnt_we, shape_we;

   logic [NUM_BITS-1:0]   num_w;
   logic [DEN_BITS-1:0]   den_w;
   logic [FAC_BITS-1:0]   fac_w;
   logic [DEN_BITS:0]     trial;
   logic [Q_BITS-1:0]     q_eff, mul_a;
   logic [CHUNK_BITS-1:0] mul_b;
   logic [PROD_BITS-1:0]  prod;
   logic [75:0]           sum_ext;
   logic [SUM_BITS-1:0]   mul_res, sum_next;
   logic [SUM_BITS:0]     sum_add;

   // ---------------- status ----------------
   assign status.sample    = sample_ff;
   assign status.old_valid = (cur_ff != 7'd0) && (cur_ff <= 7'(NUM_TOPICS));
   assign status.old_topic = TOPIC_BITS'(cur_ff - 7'd1);
   assign status.cum_ge    = (cum_rd >= mul_res);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // ---------------- count and shape tables ----------------
   assign doc_addr   = cmd.clear_wr ? cmd.clear_addr[DOC_BITS+TOPIC_BITS-1:0]
                                    : {doc_ff, cmd.topic};
   assign word_addr  = cmd.clear_wr ? cmd.clear_addr : {word_ff, cmd.topic};
   assign tot_addr   = cmd.clear_wr ? cmd.clear_addr[TOPIC_BITS-1:0] : cmd.topic;
   assign shape_addr = cmd.clear_wr ? cmd.clear_addr[DOC_BITS+TOPIC_BITS-1:0]
                     : (cmd.wr_shape ? {doc_ff, lt_ff} : {doc_ff, cmd.topic});
   assign cnt_we     = cmd.clear_wr || cmd.wr_dec || cmd.wr_inc;
   assign shape_we   = cmd.clear_wr || cmd.wr_shape;
   assign shape_wd   = cmd.clear_wr ? '0 : shape_ff;

   always_comb begin
      doc_wd  = '0;
      word_wd = '0;
      tot_wd  = '0;
      if (cmd.wr_dec) begin
         doc_wd  = (doc_rd == '0)  ? '0 : doc_rd - 1'b1;
         word_wd = (word_rd == '0) ? '0 : word_rd - 1'b1;
         tot_wd  = (tot_rd == '0)  ? '0 : tot_rd - 1'b1;
      end else if (cmd.wr_inc) begin
         doc_wd  = (&doc_rd)  ? doc_rd  : doc_rd + 1'b1;
         word_wd = (&word_rd) ? word_rd : word_rd + 1'b1;
         tot_wd  = (&tot_rd)  ? tot_rd  : tot_rd + 1'b1;
      end
   end

   cgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << (DOC_BITS + TOPIC_BITS))) u_doc_ram (
      .clock(clock), .we(cnt_we), .waddr(doc_addr), .wdata(doc_wd),
      .raddr(doc_addr), .rdata(doc_rd)
   );

   cgts_ram #(.WIDTH(COUNT_BITS), .DEPTH(1 << (WORD_BITS + TOPIC_BITS))) u_word_ram (
      .clock(clock), .we(cnt_we), .waddr(word_addr), .wdata(word_wd),
      .raddr(word_addr), .rdata(word_rd)
   );

   cgts_ram #(.WIDTH(TOTAL_BITS), .DEPTH(NUM_TOPICS)) u_tot_ram (
      .clock(clock), .we(cnt_we), .waddr(tot_addr), .wdata(tot_wd),
      .raddr(tot_addr), .rdata(tot_rd)
   );

   cgts_ram #(.WIDTH(32), .DEPTH(1 << (DOC_BITS + TOPIC_BITS))) u_shape_ram (
      .clock(clock), .we(shape_we), .waddr(shape_addr), .wdata(shape_wd),
      .raddr(shape_addr), .rdata(shape_rd)
   );

   cgts_ram #(.WIDTH(SUM_BITS), .DEPTH(NUM_TOPICS)) u_cum_ram (
      .clock(clock), .we(cmd.acc_write), .waddr(cmd.topic), .wdata(sum_next),
      .raddr(cmd.topic), .rdata(cum_rd)
   );

   // ---------------- weight terms ----------------
   assign num_w = NUM_BITS'(prior_eta) + NUM_BITS'({word_rd, 16'h0000});
   assign den_w = DEN_BITS'(vden_ff) + DEN_BITS'({tot_rd, 16'h0000});
   assign fac_w = FAC_BITS'({doc_rd, 16'h0000}) + FAC_BITS'(shape_rd);

   // restoring divide, one quotient bit per step
   assign trial = {rem_ff, dsh_ff[Q_BITS-1]};
   assign q_eff = sat_ff ? '1 : q_ff;

   // multiply by 19-bit chunks, most significant chunk first
   assign sum_ext = {12'h000, sum_ff};
   always_comb begin
      mul_a = (cmd.mul_mode == MUL_TARGET) ? Q_BITS'(rf_ff) : q_eff;
      mul_b = '0;
      if (cmd.mul_mode == MUL_WEIGHT) begin
         mul_b = cmd.chunk[0] ? fac_ff[37:19] : fac_ff[18:0];
      end else begin
         unique case (cmd.chunk)
            2'd0: mul_b = sum_ext[18:0];
            2'd1: mul_b = sum_ext[37:19];
            2'd2: mul_b = sum_ext[56:38];
            2'd3: mul_b = sum_ext[75:57];
            default: mul_b = '0;
         endcase
      end
   end

   assign prod    = mul_a * mul_b;
   assign acc_in  = cmd.mul_first ? ACC_BITS'(prod)
                  : {acc_ff[ACC_BITS-CHUNK_BITS-1:0], {CHUNK_BITS{1'b0}}} + ACC_BITS'(prod);
   assign mul_res = (|acc_ff[ACC_BITS-1:96]) ? '1 : acc_ff[95:32];
   assign sum_add = {1'b0, sum_ff} + {1'b0, mul_res};
   assign sum_next = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         word_ff   <= req_tdata[11:0];
         doc_ff    <= req_tdata[21:12];
         cur_ff    <= req_tdata[28:22];
         lt_ff     <= req_tdata[34:29];
         shape_ff  <= req_tdata[66:35];
         rf_ff     <= req_tdata[98:67];
         sample_ff <= req_tuser;
         last_ff   <= req_tlast;
         vden_ff   <= vocab_in_use * prior_eta;
         sum_ff    <= '0;
         under_ff  <= 1'b0;
      end
      if (cmd.wr_dec) begin
         under_ff <= (doc_rd == '0) || (word_rd == '0) || (tot_rd == '0);
      end
      if (cmd.w_load) begin
         den_ff <= den_w;
         fac_ff <= fac_w;
         sat_ff <= {27'h0, num_w} >= {2'b00, den_w, 16'h0000};
         rem_ff <= DEN_BITS'(num_w[NUM_BITS-1:16]);
         dsh_ff <= {num_w[15:0], 32'h0000_0000};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         dsh_ff <= {dsh_ff[Q_BITS-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= DEN_BITS'(trial - {1'b0, den_ff});
            q_ff   <= {q_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DEN_BITS-1:0];
            q_ff   <= {q_ff[Q_BITS-2:0], 1'b0};
         end
      end
      if (cmd.mul_step) begin
         acc_ff <= acc_in;
      end
      if (cmd.acc_write) begin
         sum_ff <= sum_next;
      end
      if (cmd.rsp_load) begin
         rsp_topic_ff <= sample_ff ? {1'b0, cmd.topic} + 7'd1 : 7'd0;
         rsp_under_ff <= sample_ff && under_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_under_ff, rsp_topic_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/collapsed_gibbs_topic_sampler.sv]
// ---------------------------------------------------------------------------
// collapsed_gibbs_topic_sampler
// Resamples the topic of one word token from per-document and per-word
// topic counts, and loads per-document-topic shape priors.
// ---------------------------------------------------------------------------
// One item is handled at a time. After reset a clearing pass zeroes
// the count and shape tables; no beat is taken meanwhile, configuration
// writes are. A shape load writes one entry of the shape table. A sample
// walks the 64 topics in turn through the shared bit-serial divider
// and a two-step multiply,
// then a 4-step target multiply, a 6-probe binary search over the
// cumulative RAM, and the read-modify-write of the counts. The result
// sits in an output register, so the next beat is taken while it waits.
`include "assert_macros.svh"

module collapsed_gibbs_topic_sampler (
   input  logic         clock,
   input  logic         reset,
   // request beat
   input  logic         req_tvalid,
   output logic         req_tready,
   // [11:0] word_index, [21:12] doc_index, [28:22] current_topic,
   // [34:29] load_topic, [66:35] shape_value, [98:67] random_fraction
   input  logic [103:0] req_tdata,
   input  logic         req_tuser,   // [0] cmd: 0 shape load, 1 sample
   input  logic         req_tlast,   // last_token
   // response beat
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [6:0] new_topic, [7] count_underflow
   output logic         rsp_tlast,   // sweep_end
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   import cgts_pkg::*;

   logic [ETA_BITS-1:0]   eta_ff;
   logic [VOCAB_BITS-1:0] vocab_ff;
   cmd_type               cmd;
   status_type            status;
   state_type             state;

   // registers are always writable; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff   <= ETA_RESET;
         vocab_ff <= VOCAB_RESET;
      end else if (csr_valid) begin
         if (csr_addr == CSR_PRIOR_ETA) begin
            eta_ff <= csr_wdata;
         end
         if (csr_addr == CSR_VOCAB_IN_USE) begin
            vocab_ff <= csr_wdata[VOCAB_BITS-1:0];
         end
      end
   end

   cgts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   cgts_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .prior_eta    (eta_ff),
      .vocab_in_use (vocab_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   // checks
   `ASSERT_NEXT(a_rsp_after_load, clock, reset, cmd.rsp_load, rsp_tvalid)
   `ASSERT_IMPLIES(a_no_take_clear, clock, reset, state == ST_CLEAR, !req_tready)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule
